FILE: src/dfp_pkg.sv
// Shared constants, types and codes for the depth frame preprocessor.
package dfp_pkg;

  // Default geometry, handed to the top-level parameters.
  localparam int DEF_RESIZE_ROWS = 60;
  localparam int DEF_RESIZE_COLS = 106;
  localparam int DEF_CROP_COLS   = 10;
  localparam int DEF_MAX_IN_DIM  = 4096;

  // Field widths.
  localparam int DIM_W     = 13;
  localparam int DEPTH_W   = 16;
  localparam int NORM_W    = 17;
  localparam int ROW_W     = 5;
  localparam int COL_W     = 6;
  localparam int COL_IDX_W = 8;   // covers pooled columns up to the largest resize width
  localparam int VAL_W     = 13;
  localparam int PAIR_W    = 14;
  localparam int SUM_W     = 15;

  // Config port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 1'b1;
  localparam logic [DIM_W-1:0] IN_HEIGHT_RESET = 13'd480;
  localparam logic [DIM_W-1:0] IN_WIDTH_RESET  = 13'd640;

  // Pixel conditioning.
  localparam logic [VAL_W-1:0] INVALID_FILL = 13'd5000;
  localparam logic [VAL_W-1:0] CLAMP_LO     = 13'd100;
  localparam logic [VAL_W-1:0] CLAMP_HI     = 13'd5000;

  // Normalization: q = floor((S*4096 + 625) / 1250), out = q - 32768.
  localparam int SCALE_SHIFT = 12;
  localparam int NUM_W       = SUM_W + SCALE_SHIFT;
  localparam int ROUND_BIAS  = 625;
  localparam int DIVISOR     = 1250;
  localparam int RECIP_SHIFT = 37;
  localparam int RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP_MUL =
    RECIP_W'((64'd1 << RECIP_SHIFT) / DIVISOR);
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int QUO_W       = PROD_W - RECIP_SHIFT;
  localparam int REM_W       = QUO_W + 11;
  localparam int Q_W         = QUO_W + 1;
  localparam int NORM_OFFSET = 32768;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [0:0] {
    OP_STORE = 1'b0,   // even resized row: park the horizontal pair
    OP_EMIT  = 1'b1    // odd resized row: finish the 2x2 block
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [COL_IDX_W-1:0] col;
    logic [PAIR_W-1:0]    pair;
    logic [ROW_W-1:0]     row;
    logic                 last;
  } qitem_t;

endpackage

FILE: src/dfp_pixel_if.sv
// Input channel carrying raw depth pixels.
interface dfp_pixel_if;
  import dfp_pkg::*;

  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] depth_mm;
  logic               frame_start;

  modport source (output valid, output depth_mm, output frame_start, input ready);
  modport sink   (input valid, input depth_mm, input frame_start, output ready);
endinterface

FILE: src/dfp_pooled_if.sv
// Output channel carrying pooled, normalized depth pixels.
interface dfp_pooled_if;
  import dfp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [NORM_W-1:0] depth_norm;
  logic [ROW_W-1:0]         out_row;
  logic [COL_W-1:0]         out_col;
  logic                     frame_last;

  modport source (output valid, output depth_norm, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input depth_norm, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

FILE: src/dfp_front.sv
// Front part: pixel clamp, resize selection, crop and horizontal pairing.
module dfp_front
  import dfp_pkg::*;
#(
  parameter int RESIZE_ROWS = DEF_RESIZE_ROWS,
  parameter int RESIZE_COLS = DEF_RESIZE_COLS,
  parameter int CROP_COLS   = DEF_CROP_COLS,
  parameter int MAX_IN_DIM  = DEF_MAX_IN_DIM
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [DIM_W-1:0] in_height,
  input  logic [DIM_W-1:0] in_width,
  dfp_pixel_if.sink        depth,
  input  logic             full,
  output logic             push,
  output qitem_t           push_item
);

  localparam int RC_W   = $clog2(MAX_IN_DIM);
  localparam int EFF_W  = $clog2(MAX_IN_DIM + 1);
  localparam int CMP_W  = RC_W + 1;
  localparam int RA_W   = $clog2(RESIZE_ROWS * MAX_IN_DIM + 1);
  localparam int CA_W   = $clog2(RESIZE_COLS * MAX_IN_DIM + 1);
  localparam int RR_W   = $clog2(RESIZE_ROWS + 1);
  localparam int RCOL_W = $clog2(RESIZE_COLS + 1);
  localparam int KEPT_COLS = (RESIZE_COLS > 2 * CROP_COLS) ? RESIZE_COLS - 2 * CROP_COLS : 0;
  localparam int OUT_COLS  = KEPT_COLS / 2;
  localparam int OUT_ROWS  = RESIZE_ROWS / 2;

  logic [RC_W-1:0]   row_count, col_count;
  logic [RA_W-1:0]   row_acc, row_lim;
  logic [CA_W-1:0]   col_acc, col_lim;
  logic [RR_W-1:0]   rrow;
  logic [RCOL_W-1:0] rcol;
  logic [VAL_W-1:0]  half;

  logic [RC_W-1:0]   cur_rc, cur_cc;
  logic [RA_W-1:0]   cur_racc, cur_rlim;
  logic [CA_W-1:0]   cur_cacc, cur_clim;
  logic [RR_W-1:0]   cur_rr;
  logic [RCOL_W-1:0] cur_rcol;
  logic [VAL_W-1:0]  cur_half;

  logic [EFF_W-1:0]  h_eff, w_eff;
  logic [VAL_W-1:0]  v;
  logic              row_hit, col_hit, kept, accept, row_end, frame_end;
  logic [RCOL_W-1:0] kc;
  logic [RCOL_W-2:0] j;

  logic [RC_W-1:0]   row_count_next, col_count_next;
  logic [RA_W-1:0]   row_acc_next, row_lim_next;
  logic [CA_W-1:0]   col_acc_next, col_lim_next;
  logic [RR_W-1:0]   rrow_next;
  logic [RCOL_W-1:0] rcol_next;
  logic [VAL_W-1:0]  half_next;

  // Zero acts as one, anything above the maximum acts as the maximum.
  always_comb begin
    if (in_height == '0)                   h_eff = EFF_W'(1);
    else if (32'(in_height) > MAX_IN_DIM)  h_eff = EFF_W'(MAX_IN_DIM);
    else                                   h_eff = EFF_W'(in_height);
    if (in_width == '0)                    w_eff = EFF_W'(1);
    else if (32'(in_width) > MAX_IN_DIM)   w_eff = EFF_W'(MAX_IN_DIM);
    else                                   w_eff = EFF_W'(in_width);
  end

  always_comb begin
    if (depth.depth_mm == '0)                            v = INVALID_FILL;
    else if (depth.depth_mm < DEPTH_W'(CLAMP_LO))        v = CLAMP_LO;
    else if (depth.depth_mm > DEPTH_W'(CLAMP_HI))        v = CLAMP_HI;
    else                                                 v = VAL_W'(depth.depth_mm);
  end

  // A frame start mark clears the frame state before this pixel is used.
  always_comb begin
    if (depth.frame_start) begin
      cur_rc   = '0;
      cur_cc   = '0;
      cur_racc = '0;
      cur_cacc = '0;
      cur_rlim = RA_W'(RESIZE_ROWS);
      cur_clim = CA_W'(RESIZE_COLS);
      cur_rr   = '0;
      cur_rcol = '0;
      cur_half = '0;
    end else begin
      cur_rc   = row_count;
      cur_cc   = col_count;
      cur_racc = row_acc;
      cur_cacc = col_acc;
      cur_rlim = row_lim;
      cur_clim = col_lim;
      cur_rr   = rrow;
      cur_rcol = rcol;
      cur_half = half;
    end
  end

  assign row_hit = (32'(cur_rr) < RESIZE_ROWS) && (cur_racc < cur_rlim);
  assign col_hit = (32'(cur_rcol) < RESIZE_COLS) && (cur_cacc < cur_clim);
  assign kc      = cur_rcol - RCOL_W'(CROP_COLS);
  assign j       = kc[RCOL_W-1:1];
  assign kept    = row_hit && col_hit && (32'(cur_rcol) >= CROP_COLS) && (32'(j) < OUT_COLS);

  assign depth.ready = !full;
  assign accept      = depth.valid && !full;
  assign push        = accept && kept && kc[0];

  always_comb begin
    push_item.op   = cur_rr[0] ? OP_EMIT : OP_STORE;
    push_item.col  = COL_IDX_W'(j);
    push_item.pair = PAIR_W'(cur_half) + PAIR_W'(v);
    push_item.row  = ROW_W'(cur_rr >> 1);
    push_item.last = (32'(cur_rr >> 1) == OUT_ROWS - 1) && (32'(j) == OUT_COLS - 1);
  end

  assign row_end   = (CMP_W'(cur_cc) + CMP_W'(1)) >= CMP_W'(w_eff);
  assign frame_end = (CMP_W'(cur_rc) + CMP_W'(1)) >= CMP_W'(h_eff);

  always_comb begin
    row_count_next = cur_rc;
    row_acc_next   = cur_racc;
    row_lim_next   = cur_rlim;
    rrow_next      = cur_rr;
    half_next      = (kept && !kc[0]) ? v : cur_half;
    if (row_end) begin
      col_count_next = '0;
      col_lim_next   = CA_W'(RESIZE_COLS);
      col_acc_next   = '0;
      rcol_next      = '0;
      if (frame_end) begin
        row_count_next = '0;
        row_lim_next   = RA_W'(RESIZE_ROWS);
        row_acc_next   = '0;
        rrow_next      = '0;
        half_next      = '0;
      end else begin
        row_count_next = cur_rc + RC_W'(1);
        row_lim_next   = cur_rlim + RA_W'(RESIZE_ROWS);
        if (row_hit) begin
          rrow_next    = cur_rr + RR_W'(1);
          row_acc_next = cur_racc + RA_W'(h_eff);
        end
      end
    end else begin
      col_count_next = cur_cc + RC_W'(1);
      col_lim_next   = cur_clim + CA_W'(RESIZE_COLS);
      col_acc_next   = col_hit ? cur_cacc + CA_W'(w_eff) : cur_cacc;
      rcol_next      = col_hit ? cur_rcol + RCOL_W'(1) : cur_rcol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      row_acc   <= '0;
      col_acc   <= '0;
      row_lim   <= RA_W'(RESIZE_ROWS);
      col_lim   <= CA_W'(RESIZE_COLS);
      rrow      <= '0;
      rcol      <= '0;
      half      <= '0;
    end else if (accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
      row_acc   <= row_acc_next;
      col_acc   <= col_acc_next;
      row_lim   <= row_lim_next;
      col_lim   <= col_lim_next;
      rrow      <= rrow_next;
      rcol      <= rcol_next;
      half      <= half_next;
    end
  end

endmodule

FILE: src/dfp_queue.sv
// Short FIFO of pairing operations between the front and back parts.
module dfp_queue
  import dfp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qitem_t push_item,
  output logic   full,
  input  logic   pop,
  output qitem_t pop_item,
  output logic   empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qitem_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/dfp_back.sv
// Back part: line store, vertical sum and Q.16 normalization pipeline.
module dfp_back
  import dfp_pkg::*;
#(
  parameter int RESIZE_COLS = DEF_RESIZE_COLS,
  parameter int CROP_COLS   = DEF_CROP_COLS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         empty,
  input  qitem_t       pop_item,
  output logic         pop,
  dfp_pooled_if.source pooled
);

  localparam int KEPT_COLS = (RESIZE_COLS > 2 * CROP_COLS) ? RESIZE_COLS - 2 * CROP_COLS : 0;
  localparam int OUT_COLS  = KEPT_COLS / 2;
  localparam int SLOTS     = (OUT_COLS > 0) ? OUT_COLS : 1;
  localparam int ADDR_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [PAIR_W-1:0] line_store [SLOTS];
  logic [ADDR_W-1:0] addr;
  logic              adv;

  // Stage 1: line store read.
  logic              v1;
  logic [PAIR_W-1:0] rd1, pair1;
  logic [ROW_W-1:0]  row1;
  logic [COL_W-1:0]  col1;
  logic              last1;
  // Stage 2: scaled and biased sum.
  logic              v2;
  logic [NUM_W-1:0]  num2;
  logic [ROW_W-1:0]  row2;
  logic [COL_W-1:0]  col2;
  logic              last2;
  // Stage 3: reciprocal product.
  logic              v3;
  logic [NUM_W-1:0]  num3;
  logic [PROD_W-1:0] prod3;
  logic [ROW_W-1:0]  row3;
  logic [COL_W-1:0]  col3;
  logic              last3;

  logic [SUM_W-1:0]  sum1;
  logic [QUO_W-1:0]  quo;
  logic [REM_W-1:0]  rem;
  logic [Q_W-1:0]    q;

  assign adv  = !pooled.valid || pooled.ready;
  assign pop  = !empty && adv;
  assign addr = pop_item.col[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (pop && pop_item.op == OP_STORE) line_store[addr] <= pop_item.pair;
    if (adv) rd1 <= line_store[addr];
  end

  assign sum1 = SUM_W'(rd1) + SUM_W'(pair1);

  // Quotient estimate is exact or one short; the remainder check fixes it.
  always_comb begin
    quo = prod3[PROD_W-1:RECIP_SHIFT];
    rem = REM_W'(num3) - REM_W'(quo) * REM_W'(DIVISOR);
    q   = Q_W'(quo) + ((rem >= REM_W'(DIVISOR)) ? Q_W'(1) : Q_W'(0));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pair1 <= pop_item.pair;
      row1  <= pop_item.row;
      col1  <= COL_W'(pop_item.col);
      last1 <= pop_item.last;

      num2  <= (NUM_W'(sum1) << SCALE_SHIFT) + NUM_W'(ROUND_BIAS);
      row2  <= row1;
      col2  <= col1;
      last2 <= last1;

      prod3 <= PROD_W'(num2) * PROD_W'(RECIP_MUL);
      num3  <= num2;
      row3  <= row2;
      col3  <= col2;
      last3 <= last2;

      pooled.depth_norm <= $signed(NORM_W'(q - Q_W'(NORM_OFFSET)));
      pooled.out_row    <= row3;
      pooled.out_col    <= col3;
      pooled.frame_last <= last3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      pooled.valid <= 1'b0;
    end else if (adv) begin
      v1           <= pop && pop_item.op == OP_EMIT;
      v2           <= v1;
      v3           <= v2;
      pooled.valid <= v3;
    end
  end

endmodule

FILE: src/depth_frame_preprocess_top.sv
// Streaming depth preprocessor: resize, crop, clamp, 2x2 average pool, Q.16 normalize.
//
// Depth pixels in millimeters arrive in raster order on the depth channel, one
// item per cycle at full rate. Zero (invalid) pixels become 5000 mm. A
// nearest-neighbor resize maps the in_height x in_width frame to 60x106,
// columns 10..95 are kept, values are clamped to 100..5000 mm, and each 2x2
// block yields one pooled item (S/20000 - 0.5 in Q.16) on the pooled channel,
// a 30x43 frame with frame_last on its final item. frame_start on a pixel
// restarts the frame at row 0, column 0; without it the counters wrap after
// the last input pixel. Program in_height and in_width only while idle; they
// should be at least 60 and 106. Throughput: one pixel per cycle; the depth
// channel holds ready low only while the four-entry operation queue is full,
// which happens only when the pooled channel is stalled. After its operation
// leaves the queue, a pooled item passes line store read, sum and scale,
// reciprocal multiply and remainder correction into the output register.
module depth_frame_preprocess_top
  import dfp_pkg::*;
#(
  parameter int RESIZE_ROWS = DEF_RESIZE_ROWS,
  parameter int RESIZE_COLS = DEF_RESIZE_COLS,
  parameter int CROP_COLS   = DEF_CROP_COLS,
  parameter int MAX_IN_DIM  = DEF_MAX_IN_DIM
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  dfp_pixel_if.sink            depth,
  dfp_pooled_if.source         pooled
);

  logic [DIM_W-1:0] in_height, in_width;

  // Front-to-back operation queue.
  logic   push, pop, full, empty;
  qitem_t push_item, pop_item;

  // Frame geometry registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_height <= IN_HEIGHT_RESET;
      in_width  <= IN_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IN_HEIGHT: in_height <= cfg_data;
        REG_IN_WIDTH:  in_width  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Front: classifies each pixel into store / emit operations.
  dfp_front #(
    .RESIZE_ROWS (RESIZE_ROWS),
    .RESIZE_COLS (RESIZE_COLS),
    .CROP_COLS   (CROP_COLS),
    .MAX_IN_DIM  (MAX_IN_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_height (in_height),
    .in_width  (in_width),
    .depth     (depth),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  dfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  // Back: line store and normalization, stalls only on the pooled channel.
  dfp_back #(
    .RESIZE_COLS (RESIZE_COLS),
    .CROP_COLS   (CROP_COLS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_item (pop_item),
    .pop      (pop),
    .pooled   (pooled)
  );

endmodule
